// ===== rtl/i2c_master_bit_sequencer_unit_assert.svh =====
// Assertion macros for the I2C master bit sequencer.
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define I2CMS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define I2CMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cms_pkg.sv =====
// Shared types and constants of the I2C master bit sequencer.
package i2cms_pkg;

  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;
  localparam logic [2:0] CMD_ACK   = 3'd6;
  localparam logic [2:0] CMD_NACK  = 3'd7;

  localparam logic [1:0] CFG_PHASE_TICKS      = 2'd0;
  localparam logic [1:0] CFG_READ_PHASE_TICKS = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT      = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RST      = 16'd720;
  localparam logic [15:0] READ_PHASE_TICKS_RST = 16'd144;
  localparam logic [7:0]  ACK_TIMEOUT_RST      = 8'd50;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

endpackage

// ===== rtl/i2cms_in_stage.sv =====
// Input register stage: holds one request until the sequencer core takes it.
module i2cms_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  i2cms_pkg::item_t item_i,
  input  logic             take_i,
  output logic             vld_o,
  output i2cms_pkg::item_t item_o
);
  import i2cms_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== rtl/i2cms_core.sv =====
// Sequencer core: bus state, config registers and the one-tick update.
module i2cms_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             go_i,
  input  i2cms_pkg::item_t item_i,
  output i2cms_pkg::res_t  res_o
);
  import i2cms_pkg::*;

  logic [15:0] phase_ticks_q, read_ticks_q;
  logic [7:0]  ack_timeout_q;

  logic [2:0]  cmd_q, cmd_d;
  logic [1:0]  step_q, step_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  poll_q, poll_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic [7:0]  rx_q, rx_d;
  logic        err_q, err_d;
  logic        done;

  logic [15:0] len_sel, len, tick_inc;
  logic [7:0]  shift_nxt;
  logic [1:0]  lines;

  // Drive levels applied on the first tick of a phase: {scl, sda}.
  function automatic logic [1:0] phase_lines(input logic [2:0] c, input logic [1:0] s,
                                             input logic dbit, input logic scl,
                                             input logic sda);
    logic sc;
    logic sd;
    sc = scl;
    sd = sda;
    case (c)
      CMD_START: begin
        if (s == 2'd0) sd = 1'b1;
        else if (s == 2'd1) sc = 1'b1;
        else if (s == 2'd2) sd = 1'b0;
        else sc = 1'b0;
      end
      CMD_STOP: begin
        if (s == 2'd0) sc = 1'b0;
        else if (s == 2'd1) sd = 1'b0;
        else if (s == 2'd2) sc = 1'b1;
        else sd = 1'b1;
      end
      CMD_SEND: begin
        if (s == 2'd0) sc = 1'b0;
        else if (s == 2'd1) sd = dbit;
        else if (s == 2'd2) sc = 1'b1;
        else sc = 1'b0;
      end
      CMD_WAIT: begin
        if (s == 2'd0) sc = 1'b0;
        else if (s == 2'd1) sd = 1'b1;
        else if (s == 2'd2) sc = 1'b1;
      end
      CMD_READ: begin
        if (s == 2'd0) begin
          sd = 1'b1;
          sc = 1'b0;
        end else begin
          sc = 1'b1;
        end
      end
      CMD_ACK: begin
        if (s == 2'd0) begin
          sc = 1'b0;
          sd = 1'b0;
        end else begin
          sc = 1'b1;
        end
      end
      CMD_NACK: begin
        if (s == 2'd0) begin
          sc = 1'b0;
          sd = 1'b1;
        end else if (s == 2'd1) begin
          sc = 1'b1;
        end else begin
          sc = 1'b0;
        end
      end
      default: ;
    endcase
    return {sc, sd};
  endfunction

  assign len_sel  = (cmd_q == CMD_READ) ? read_ticks_q : phase_ticks_q;
  assign len      = (len_sel == 16'd0) ? 16'd1 : len_sel;
  assign tick_inc = tick_q + 16'd1;
  assign shift_nxt = (cmd_q == CMD_READ) ? {shift_q[6:0], item_i.sda_in}
                                         : {shift_q[6:0], 1'b0};

  always_comb begin
    cmd_d   = cmd_q;
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tick_d  = tick_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rx_d    = rx_q;
    err_d   = err_q;
    done    = 1'b0;
    lines   = {scl_q, sda_q};

    if (cmd_q == CMD_IDLE) begin
      if (item_i.cmd != CMD_IDLE) begin
        cmd_d  = item_i.cmd;
        step_d = 2'd0;
        bit_d  = 3'd0;
        poll_d = 8'd0;
        tick_d = 16'd0;
        if (item_i.cmd == CMD_SEND) shift_d = item_i.tx_byte;
        if (item_i.cmd == CMD_READ) shift_d = 8'd0;
        if (item_i.cmd == CMD_WAIT) err_d = 1'b0;
        lines = phase_lines(item_i.cmd, 2'd0, item_i.tx_byte[7], scl_q, sda_q);
        scl_d = lines[1];
        sda_d = lines[0];
      end
    end else if (cmd_q == CMD_WAIT && step_q == 2'd3) begin
      // ack poll, one sample per tick
      if (!item_i.sda_in) begin
        scl_d = 1'b0;
        done  = 1'b1;
      end else if (poll_q >= ack_timeout_q) begin
        err_d  = 1'b1;
        cmd_d  = CMD_STOP;
        poll_d = 8'd0;
        step_d = 2'd0;
        tick_d = 16'd0;
        scl_d  = 1'b0;
      end else begin
        poll_d = poll_q + 8'd1;
      end
    end else if (tick_inc < len) begin
      tick_d = tick_inc;
    end else begin
      tick_d = 16'd0;
      case (cmd_q)
        CMD_START, CMD_STOP, CMD_WAIT: begin
          if (step_q != 2'd3) step_d = step_q + 2'd1;
          else done = 1'b1;
        end
        CMD_SEND: begin
          if (step_q != 2'd3) begin
            step_d = step_q + 2'd1;
          end else begin
            shift_d = shift_nxt;
            bit_d   = bit_q + 3'd1;
            if (bit_q != 3'd7) step_d = 2'd1;
            else done = 1'b1;
          end
        end
        CMD_READ: begin
          if (step_q == 2'd0) begin
            step_d = 2'd1;
          end else begin
            shift_d = shift_nxt;
            bit_d   = bit_q + 3'd1;
            if (bit_q != 3'd7) begin
              step_d = 2'd0;
            end else begin
              rx_d = shift_nxt;
              done = 1'b1;
            end
          end
        end
        CMD_ACK: begin
          if (step_q == 2'd0) begin
            step_d = 2'd1;
          end else begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        end
        CMD_NACK: begin
          if (step_q != 2'd2) step_d = step_q + 2'd1;
          else done = 1'b1;
        end
        default: done = 1'b1;
      endcase
      if (!done) begin
        lines = phase_lines(cmd_q, step_d, shift_d[7], scl_q, sda_q);
        scl_d = lines[1];
        sda_d = lines[0];
      end
    end

    if (done) begin
      cmd_d  = CMD_IDLE;
      step_d = 2'd0;
      bit_d  = 3'd0;
      tick_d = 16'd0;
      poll_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      read_ticks_q  <= READ_PHASE_TICKS_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PHASE_TICKS:      phase_ticks_q <= cfg_data_i;
        CFG_READ_PHASE_TICKS: read_ticks_q  <= cfg_data_i;
        CFG_ACK_TIMEOUT:      ack_timeout_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_IDLE;
      step_q  <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      tick_q  <= 16'd0;
      poll_q  <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rx_q    <= 8'd0;
      err_q   <= 1'b0;
    end else if (go_i) begin
      cmd_q   <= cmd_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      poll_q  <= poll_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
    end
  end

  assign res_o.scl_out     = scl_d;
  assign res_o.sda_out     = sda_d;
  assign res_o.busy_res    = (cmd_d != CMD_IDLE);
  assign res_o.done_res    = done;
  assign res_o.rx_byte     = rx_d;
  assign res_o.ack_missing = err_d;

endmodule

// ===== rtl/i2cms_out_stage.sv =====
// Result register: holds one result until the consumer takes it.
module i2cms_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  i2cms_pkg::res_t res_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output i2cms_pkg::res_t res_o
);
  import i2cms_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign ready_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (vld_q && !out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/i2c_master_bit_sequencer_unit.sv =====
// I2C master bit sequencer top level: input register, sequencer core, result register.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   in      | to block  | in_valid_i / in_stall_o    | cmd_i, tx_byte_i, sda_in_i
//   out     | from block| out_valid_o / out_stall_i  | scl_out_o .. ack_missing_o
//   cfg     | to block  | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One request (one bus tick) per cycle while the output is not stalled. Each one waits
// in the input register; once taken, its result goes through the core into the result
// register. The core's state update is combinational, which sets the one-per-cycle rate.
// Reset puts the bus lines released, the sequencer idle and config at its defaults.
// A stalled output holds the core; the input then stalls once its register is full.
module i2c_master_bit_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_missing_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import i2cms_pkg::*;

`include "i2c_master_bit_sequencer_unit_assert.svh"

  item_t item_in, item_q;
  res_t  res_core, res_q;
  logic  in_vld, out_ready, take;

  assign item_in.cmd     = cmd_i;
  assign item_in.tx_byte = tx_byte_i;
  assign item_in.sda_in  = sda_in_i;

  assign take = in_vld & out_ready;

  i2cms_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (take),
    .vld_o      (in_vld),
    .item_o     (item_q)
  );

  i2cms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .go_i        (take),
    .item_i      (item_q),
    .res_o       (res_core)
  );

  i2cms_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res_core),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign scl_out_o     = res_q.scl_out;
  assign sda_out_o     = res_q.sda_out;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign rx_byte_o     = res_q.rx_byte;
  assign ack_missing_o = res_q.ack_missing;

  `I2CMS_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, take && res_core.done_res, !res_core.busy_res, "done reported while still busy")
  `I2CMS_ASSERT_NOW(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_vld, "input stalled with empty register")
  `I2CMS_ASSERT_NEXT(a_take_fills_out, clk_i, rst_ni, take, out_valid_o, "taken request left no result")

endmodule

// ===== verif/i2c_master_bit_sequencer_unit_checker.sv =====
// Checker for the I2C master bit sequencer: bus tick predictor and result comparison.
module i2c_master_bit_sequencer_unit_checker
  import i2cms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        sda_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        scl_out_i,
  input  logic        sda_out_i,
  input  logic        busy_res_i,
  input  logic        done_res_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        ack_missing_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_results_o,
  output logic        seq_busy_o
);

  logic [15:0] cfg_phase;
  logic [15:0] cfg_read_phase;
  logic [7:0]  cfg_timeout;

  logic [2:0]  seq_cmd;
  int unsigned seq_step;
  int unsigned seq_bit;
  int unsigned seq_ticks;
  logic [7:0]  seq_shift;
  logic [7:0]  seq_polls;
  logic        scl_drv;
  logic        sda_drv;
  logic [7:0]  rx_last;
  logic        ack_lost;

  res_t expected_bus[$];
  res_t got;
  res_t want;
  int   errors;

  function automatic int unsigned phase_len();
    logic [15:0] n;
    n = (seq_cmd == CMD_READ) ? cfg_read_phase : cfg_phase;
    return (n == 16'd0) ? 1 : n;
  endfunction

  // Drive levels applied on the first tick of each bus phase.
  function automatic void enter_step(int unsigned s);
    seq_step = s;
    seq_ticks = 0;
    case (seq_cmd)
      CMD_START: case (s)
        0: sda_drv = 1'b1;
        1: scl_drv = 1'b1;
        2: sda_drv = 1'b0;
        default: scl_drv = 1'b0;
      endcase
      CMD_STOP: case (s)
        0: scl_drv = 1'b0;
        1: sda_drv = 1'b0;
        2: scl_drv = 1'b1;
        default: sda_drv = 1'b1;
      endcase
      CMD_SEND: case (s)
        0: scl_drv = 1'b0;
        1: sda_drv = seq_shift[7];
        2: scl_drv = 1'b1;
        default: scl_drv = 1'b0;
      endcase
      CMD_WAIT: case (s)
        0: scl_drv = 1'b0;
        1: sda_drv = 1'b1;
        2: scl_drv = 1'b1;
        default: ;
      endcase
      CMD_READ: if (s == 0) begin
        sda_drv = 1'b1;
        scl_drv = 1'b0;
      end else begin
        scl_drv = 1'b1;
      end
      CMD_ACK: if (s == 0) begin
        scl_drv = 1'b0;
        sda_drv = 1'b0;
      end else begin
        scl_drv = 1'b1;
      end
      CMD_NACK: case (s)
        0: begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
        end
        1: scl_drv = 1'b1;
        default: scl_drv = 1'b0;
      endcase
      default: ;
    endcase
  endfunction

  function automatic void end_sequence();
    seq_cmd = CMD_IDLE;
    seq_step = 0;
    seq_bit = 0;
    seq_ticks = 0;
    seq_polls = '0;
  endfunction

  // One tick of a running sequence; returns the done pulse.
  function automatic logic advance(logic sda);
    if (seq_cmd == CMD_WAIT && seq_step == 3) begin
      if (!sda) begin
        scl_drv = 1'b0;
        end_sequence();
        return 1'b1;
      end
      if (seq_polls >= cfg_timeout) begin
        // no ack: fall into a stop sequence on this same tick
        ack_lost = 1'b1;
        seq_cmd = CMD_STOP;
        seq_polls = '0;
        enter_step(0);
      end else begin
        seq_polls = seq_polls + 8'd1;
      end
      return 1'b0;
    end
    seq_ticks++;
    if (seq_ticks < phase_len()) return 1'b0;
    seq_ticks = 0;
    case (seq_cmd)
      CMD_START, CMD_STOP, CMD_WAIT: begin
        if (seq_step < 3) begin
          enter_step(seq_step + 1);
          return 1'b0;
        end
      end
      CMD_SEND: begin
        if (seq_step < 3) begin
          enter_step(seq_step + 1);
          return 1'b0;
        end
        seq_shift = {seq_shift[6:0], 1'b0};
        seq_bit++;
        if (seq_bit < 8) begin
          enter_step(1);
          return 1'b0;
        end
      end
      CMD_READ: begin
        if (seq_step == 0) begin
          enter_step(1);
          return 1'b0;
        end
        seq_shift = {seq_shift[6:0], sda};
        seq_bit++;
        if (seq_bit < 8) begin
          enter_step(0);
          return 1'b0;
        end
        rx_last = seq_shift;
      end
      CMD_ACK: begin
        if (seq_step == 0) begin
          enter_step(1);
          return 1'b0;
        end
        scl_drv = 1'b0;
      end
      CMD_NACK: begin
        if (seq_step < 2) begin
          enter_step(seq_step + 1);
          return 1'b0;
        end
      end
      default: ;
    endcase
    end_sequence();
    return 1'b1;
  endfunction

  function automatic res_t bus_tick(logic [2:0] cmd, logic [7:0] tx, logic sda);
    logic done;
    res_t r;
    done = 1'b0;
    if (seq_cmd == CMD_IDLE) begin
      // commands arriving while busy fall through to advance() and are dropped
      if (cmd != CMD_IDLE) begin
        seq_cmd = cmd;
        seq_bit = 0;
        seq_polls = '0;
        if (cmd == CMD_SEND) seq_shift = tx;
        if (cmd == CMD_READ) seq_shift = '0;
        if (cmd == CMD_WAIT) ack_lost = 1'b0;
        enter_step(0);
      end
    end else begin
      done = advance(sda);
    end
    r.scl_out = scl_drv;
    r.sda_out = sda_drv;
    r.busy_res = (seq_cmd != CMD_IDLE);
    r.done_res = done;
    r.rx_byte = rx_last;
    r.ack_missing = ack_lost;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_phase = PHASE_TICKS_RST;
      cfg_read_phase = READ_PHASE_TICKS_RST;
      cfg_timeout = ACK_TIMEOUT_RST;
      seq_cmd = CMD_IDLE;
      seq_step = 0;
      seq_bit = 0;
      seq_ticks = 0;
      seq_shift = '0;
      seq_polls = '0;
      scl_drv = 1'b1;
      sda_drv = 1'b1;
      rx_last = '0;
      ack_lost = 1'b0;
      expected_bus.delete();
      errors = 0;
      mismatch_count_o <= 0;
      pending_results_o <= 0;
      seq_busy_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PHASE_TICKS:      cfg_phase = cfg_data_i;
          CFG_READ_PHASE_TICKS: cfg_read_phase = cfg_data_i;
          CFG_ACK_TIMEOUT:      cfg_timeout = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_bus.push_back(bus_tick(cmd_i, tx_byte_i, sda_in_i));
      if (out_valid_i && !out_stall_i) begin
        got = {scl_out_i, sda_out_i, busy_res_i, done_res_i, rx_byte_i, ack_missing_i};
        if (expected_bus.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding: expected none, actual %p",
                   $time, got);
        end else begin
          want = expected_bus.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch: expected %p, actual %p", $time, want, got);
          end
        end
      end
      mismatch_count_o <= errors;
      pending_results_o <= expected_bus.size();
      seq_busy_o <= (seq_cmd != CMD_IDLE);
    end
  end

endmodule

// ===== verif/tb_i2c_master_bit_sequencer_unit.sv =====
// Testbench top for the I2C master bit sequencer: stimulus, flow control and verdict.
module tb_i2c_master_bit_sequencer_unit;
  import i2cms_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int IDLE_LIMIT   = 4000;
  localparam int TOTAL_ITEMS  = 1050;
  localparam int HOLD_CYCLES  = 48;

  typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_pattern_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CMD_IDLE;
  logic [7:0]  tx_byte = '0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic        ack_missing;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PHASE_TICKS;
  logic [15:0] cfg_data = '0;

  int   mismatches;
  int   pending_results;
  logic seq_busy;

  bit           gaps_on = 1'b1;
  bit           noise_on = 1'b0;
  bit           hold_req = 1'b0;
  sda_pattern_e sda_pattern = SDA_RANDOM;
  int           items_sent = 0;

  i2c_master_bit_sequencer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .tx_byte_i    (tx_byte),
    .sda_in_i     (sda_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .scl_out_o    (scl_out),
    .sda_out_o    (sda_out),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .rx_byte_o    (rx_byte),
    .ack_missing_o(ack_missing),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  i2c_master_bit_sequencer_unit_checker bus_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .tx_byte_i        (tx_byte),
    .sda_in_i         (sda_in),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .scl_out_i        (scl_out),
    .sda_out_i        (sda_out),
    .busy_res_i       (busy_res),
    .done_res_i       (done_res),
    .rx_byte_i        (rx_byte),
    .ack_missing_i    (ack_missing),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_results_o(pending_results),
    .seq_busy_o       (seq_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic next_sda();
    case (sda_pattern)
      SDA_HIGH: return 1'b1;
      SDA_LOW:  return 1'b0;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Commands sprinkled into ticks; dropped by the block while it is busy.
  function automatic logic [2:0] noise_cmd();
    if (noise_on && $urandom_range(0, 3) == 0) return 3'($urandom_range(1, 7));
    return CMD_IDLE;
  endfunction

  task automatic put_request(input logic [2:0] c, input logic [7:0] t, input logic s);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c;
    tx_byte <= t;
    sda_in <= s;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // Issue one command, then tick until the predicted sequence is over.
  task automatic run_command(input logic [2:0] c, input logic [7:0] t, input sda_pattern_e p);
    sda_pattern = p;
    put_request(c, t, next_sda());
    do put_request(noise_cmd(), 8'($urandom_range(0, 255)), next_sda()); while (seq_busy);
  endtask

  // Bring the block to idle with every result collected.
  task automatic quiesce();
    sda_pattern = SDA_RANDOM;
    forever begin
      while (seq_busy) put_request(CMD_IDLE, 8'($urandom_range(0, 255)), next_sda());
      in_valid <= 1'b0;
      @(posedge clk_i);
      while (pending_results != 0) @(posedge clk_i);
      if (!seq_busy) break;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [15:0] p, input logic [15:0] r, input logic [7:0] t);
    quiesce();
    write_reg(CFG_PHASE_TICKS, p);
    write_reg(CFG_READ_PHASE_TICKS, r);
    write_reg(CFG_ACK_TIMEOUT, {8'($urandom_range(0, 255)), t});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
  endtask

  // Receiver: short random stall bursts plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("i2c_master_bit_sequencer_unit regression: fail");
    $finish;
  end

  initial begin
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest phases with zero register values
    set_timing(16'd0, 16'd0, 8'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    run_command(CMD_START, 8'h00, SDA_RANDOM);
    run_command(CMD_SEND, 8'h00, SDA_RANDOM);
    run_command(CMD_SEND, 8'hFF, SDA_RANDOM);
    run_command(CMD_SEND, 8'hA5, SDA_RANDOM);
    run_command(CMD_WAIT, 8'h00, SDA_HIGH);   // gives up on the first high poll
    run_command(CMD_WAIT, 8'hFF, SDA_LOW);
    run_command(CMD_READ, 8'h00, SDA_HIGH);
    run_command(CMD_READ, 8'hFF, SDA_LOW);
    run_command(CMD_READ, 8'h3C, SDA_RANDOM);
    run_command(CMD_ACK, 8'h00, SDA_RANDOM);
    run_command(CMD_NACK, 8'h00, SDA_RANDOM);
    run_command(CMD_STOP, 8'h00, SDA_RANDOM);
    noise_on = 1'b1;  // commands during a busy start are dropped
    run_command(CMD_START, 8'h81, SDA_RANDOM);
    noise_on = 1'b0;

    set_timing(16'd2, 16'd3, 8'd255);
    run_command(CMD_WAIT, 8'h00, SDA_HIGH);
    run_command(CMD_WAIT, 8'h00, SDA_RANDOM);
    run_command(CMD_SEND, 8'h5A, SDA_RANDOM);

    set_timing(16'd40, 16'd1, 8'd1);
    run_command(CMD_READ, 8'h00, SDA_RANDOM);
    run_command(CMD_ACK, 8'h00, SDA_RANDOM);
    set_timing(16'd1, 16'hFFFF, 8'd1);
    run_command(CMD_START, 8'h00, SDA_RANDOM);
    run_command(CMD_NACK, 8'h00, SDA_RANDOM);

    // random transfers: mostly well-formed frames, some loose commands
    set_timing(16'd1, 16'd1, 8'd2);
    noise_on = 1'b1;
    hold_req = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent > TOTAL_ITEMS * 4 / 5) gaps_on = 1'b0;
      if ($urandom_range(0, 3) == 0)
        set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 4)));
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      sda_pattern_e'($urandom_range(0, 2)));
      end else begin
        n = $urandom_range(1, 3);
        run_command(CMD_START, 8'($urandom_range(0, 255)), SDA_RANDOM);
        run_command(CMD_SEND, 8'($urandom_range(0, 255)), SDA_RANDOM);
        run_command(CMD_WAIT, 8'($urandom_range(0, 255)), sda_pattern_e'($urandom_range(0, 2)));
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) begin
            run_command(CMD_SEND, 8'($urandom_range(0, 255)), SDA_RANDOM);
            run_command(CMD_WAIT, 8'($urandom_range(0, 255)),
                        sda_pattern_e'($urandom_range(0, 2)));
          end else begin
            run_command(CMD_READ, 8'($urandom_range(0, 255)), SDA_RANDOM);
            run_command(($urandom_range(0, 1) == 0) ? CMD_ACK : CMD_NACK,
                        8'($urandom_range(0, 255)), SDA_RANDOM);
          end
        end
        run_command(CMD_STOP, 8'($urandom_range(0, 255)), SDA_RANDOM);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results == 0)
      $display("i2c_master_bit_sequencer_unit regression: pass");
    else
      $display("i2c_master_bit_sequencer_unit regression: fail");
    $finish;
  end

endmodule

// ===== i2c_master_bit_sequencer_unit.f =====
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2cms_in_stage.sv
rtl/i2cms_core.sv
rtl/i2cms_out_stage.sv
rtl/i2c_master_bit_sequencer_unit.sv
verif/i2c_master_bit_sequencer_unit_checker.sv
verif/tb_i2c_master_bit_sequencer_unit.sv
